### design/spi_pkg.sv
package spi_pkg;

    localparam int ENC_FIELDS = 3;
    localparam int ENC_COUNT  = 3;

    localparam int CH_GYRO  = 3;
    localparam int CH_ACCEL = 4;

    localparam logic [15:0] GAP_LIMIT_RESET = 16'd200;

    localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

    typedef struct packed {
        logic        [7:0]  sequence_req;
        logic        [31:0] pkt_stamp;
        logic        [2:0]  encoder_present;
        logic               gyro_present;
        logic               accel_present;
        logic signed [31:0] encoder_zero;
        logic signed [31:0] encoder_one;
        logic signed [31:0] encoder_two;
        logic signed [31:0] gyro_rate;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
    } t_in_item;

    typedef struct packed {
        logic        [7:0]  sequence_gap;
        logic        [15:0] device_epoch;
        logic        [31:0] packet_count;
        logic signed [63:0] rotation_sum;
        logic        [15:0] rotation_epoch;
        logic signed [31:0] held_gyro_rate;
        logic signed [31:0] held_encoder_zero;
        logic signed [31:0] held_encoder_one;
        logic signed [31:0] held_encoder_two;
        logic signed [31:0] held_accel_x;
        logic signed [31:0] held_accel_y;
        logic        [4:0]  channels_seen;
    } t_out_item;

endpackage

### design/spi_if.sv
interface spi_in_if;
    logic              valid;
    logic              ready;
    spi_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface spi_out_if;
    logic               valid;
    logic               ready;
    spi_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### design/spi_in_stage.sv
module spi_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    spi_in_if.sink            i_in,
    input  logic              i_take,
    output logic              o_valid,
    output spi_pkg::t_in_item o_item
);

    logic              r_valid;
    spi_pkg::t_in_item r_item;
    logic              w_ready;

    assign w_ready    = !r_valid || i_take;
    assign i_in.ready = w_ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_in.valid) begin
            r_item <= i_in.payload;
        end
    end

endmodule

### design/spi_update.sv
module spi_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  spi_pkg::t_in_item  i_item,
    input  logic [15:0]        i_gap_limit,
    output spi_pkg::t_out_item o_result
);

    logic                r_seen_seq;
    logic [7:0]          r_prior_seq;
    logic [31:0]         r_packets;
    logic                r_seen_stamp;
    logic [31:0]         r_prior_stamp;
    logic [15:0]         r_epoch;
    logic                r_gyro_seeded;
    logic signed [31:0]  r_prior_rate;
    logic [31:0]         r_prior_gyro_stamp;
    logic signed [63:0]  r_acc;
    logic [15:0]         r_reseed;
    logic signed [31:0]  r_enc [spi_pkg::ENC_FIELDS];
    logic signed [31:0]  r_gyro;
    logic signed [31:0]  r_accel_x;
    logic signed [31:0]  r_accel_y;
    logic [4:0]          r_flags;

    logic [7:0]          n_gap_seq;
    logic [31:0]         n_packets;
    logic [15:0]         n_epoch;
    logic [15:0]         n_reseed;
    logic signed [63:0]  n_acc;
    logic signed [31:0]  n_enc [spi_pkg::ENC_FIELDS];
    logic [4:0]          n_flags;
    logic signed [31:0]  n_gyro;
    logic signed [31:0]  n_accel_x;
    logic signed [31:0]  n_accel_y;

    logic                w_regress;
    logic                w_seeded;
    logic [32:0]         w_diff;
    logic                w_gap_ok;
    logic signed [32:0]  w_rate_sum;
    logic signed [49:0]  w_product;
    logic signed [64:0]  w_acc_sum;
    logic signed [31:0]  w_enc_in [spi_pkg::ENC_FIELDS];

    assign w_enc_in[0] = i_item.encoder_zero;
    assign w_enc_in[1] = i_item.encoder_one;
    assign w_enc_in[2] = i_item.encoder_two;

    always_comb begin
        n_gap_seq = r_seen_seq ? (i_item.sequence_req - r_prior_seq - 8'd1) : 8'd0;
        n_packets = r_packets + 32'd1;

        w_regress = r_seen_stamp && (i_item.pkt_stamp < r_prior_stamp);
        w_seeded  = r_gyro_seeded && !w_regress;
        n_epoch   = r_epoch + {15'd0, w_regress};

        w_diff   = {1'b0, i_item.pkt_stamp} - {1'b0, r_prior_gyro_stamp};
        w_gap_ok = !w_diff[32] && (w_diff[31:0] != 32'd0) && (w_diff[31:16] == 16'd0)
                   && (w_diff[15:0] <= i_gap_limit);

        w_rate_sum = 33'(r_prior_rate) + 33'(i_item.gyro_rate);
        w_product  = 50'(w_rate_sum) * $signed({34'd0, w_diff[15:0]});
        w_acc_sum  = 65'(r_acc) + 65'(w_product);

        n_acc    = r_acc;
        n_reseed = r_reseed + {15'd0, w_regress};
        n_gyro   = r_gyro;
        n_flags  = r_flags;

        if (i_item.gyro_present) begin
            if (w_seeded) begin
                if (w_gap_ok) begin
                    if (w_acc_sum[64] != w_acc_sum[63]) begin
                        n_acc = w_acc_sum[64] ? spi_pkg::ACC_MIN : spi_pkg::ACC_MAX;
                    end else begin
                        n_acc = w_acc_sum[63:0];
                    end
                end else begin
                    n_reseed = n_reseed + 16'd1;
                end
            end
            n_gyro                    = i_item.gyro_rate;
            n_flags[spi_pkg::CH_GYRO] = 1'b1;
        end

        for (int ch = 0; ch < spi_pkg::ENC_FIELDS; ch++) begin
            n_enc[ch] = r_enc[ch];
            if (ch < spi_pkg::ENC_COUNT && i_item.encoder_present[ch]) begin
                n_enc[ch]   = w_enc_in[ch];
                n_flags[ch] = 1'b1;
            end
        end

        n_accel_x = r_accel_x;
        n_accel_y = r_accel_y;
        if (i_item.accel_present) begin
            n_accel_x                  = i_item.accel_x;
            n_accel_y                  = i_item.accel_y;
            n_flags[spi_pkg::CH_ACCEL] = 1'b1;
        end
    end

    always_comb begin
        o_result.sequence_gap      = n_gap_seq;
        o_result.device_epoch      = n_epoch;
        o_result.packet_count      = n_packets;
        o_result.rotation_sum      = n_acc;
        o_result.rotation_epoch    = n_reseed;
        o_result.held_gyro_rate    = n_gyro;
        o_result.held_encoder_zero = n_enc[0];
        o_result.held_encoder_one  = n_enc[1];
        o_result.held_encoder_two  = n_enc[2];
        o_result.held_accel_x      = n_accel_x;
        o_result.held_accel_y      = n_accel_y;
        o_result.channels_seen     = n_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_seq         <= 1'b0;
            r_prior_seq        <= 8'd0;
            r_packets          <= 32'd0;
            r_seen_stamp       <= 1'b0;
            r_prior_stamp      <= 32'd0;
            r_epoch            <= 16'd0;
            r_gyro_seeded      <= 1'b0;
            r_prior_rate       <= 32'sd0;
            r_prior_gyro_stamp <= 32'd0;
            r_acc              <= 64'sd0;
            r_reseed           <= 16'd0;
            for (int ch = 0; ch < spi_pkg::ENC_FIELDS; ch++) begin
                r_enc[ch] <= 32'sd0;
            end
            r_gyro             <= 32'sd0;
            r_accel_x          <= 32'sd0;
            r_accel_y          <= 32'sd0;
            r_flags            <= 5'd0;
        end else if (i_fire) begin
            r_seen_seq    <= 1'b1;
            r_prior_seq   <= i_item.sequence_req;
            r_packets     <= n_packets;
            r_seen_stamp  <= 1'b1;
            r_prior_stamp <= i_item.pkt_stamp;
            r_epoch       <= n_epoch;
            r_gyro_seeded <= w_seeded || i_item.gyro_present;
            if (i_item.gyro_present) begin
                r_prior_rate       <= i_item.gyro_rate;
                r_prior_gyro_stamp <= i_item.pkt_stamp;
            end
            r_acc    <= n_acc;
            r_reseed <= n_reseed;
            for (int ch = 0; ch < spi_pkg::ENC_FIELDS; ch++) begin
                r_enc[ch] <= n_enc[ch];
            end
            r_gyro    <= n_gyro;
            r_accel_x <= n_accel_x;
            r_accel_y <= n_accel_y;
            r_flags   <= n_flags;
        end
    end

endmodule

### design/sensor_packet_integrator.sv
// Channel   Direction  Payload                                  Handshake
// i_in      in         sequence, stamp, presence, sensor values valid / ready
// o_out     out        gaps, epochs, count, rotation, held vals valid / ready
// i_cfg     in         gap_limit_ms (16 bit)                    i_cfg_we
//
// One request per cycle sustained while o_out is not stalled; a request taken
// at i_in sits in the input register until the result register can take it,
// and its result is then loaded into the result register and shown on o_out.
// The update path is one 33x16 multiply and a 64-bit saturating add.
// Reset is synchronous and clears all state but the input and result data
// registers; gap_limit_ms returns to 200. A stalled o_out holds its result;
// i_in keeps taking while the input register is empty or moving on.
module sensor_packet_integrator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spi_in_if.sink      i_in,
    spi_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic               r_out_valid;
    spi_pkg::t_out_item r_out;
    logic [15:0]        r_gap_limit;

    logic               w_in_valid;
    spi_pkg::t_in_item  w_in_item;
    logic               w_fire;
    spi_pkg::t_out_item w_result;

    assign w_fire = w_in_valid && (!r_out_valid || o_out.ready);

    spi_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_item  (w_in_item)
    );

    spi_update u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (w_in_item),
        .i_gap_limit (r_gap_limit),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit <= spi_pkg::GAP_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_gap_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    a_fire_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out.valid)
        else $error("update not presented at output");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while pipeline stalled full");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && $past(w_fire) && $past(i_rst_n))
            |-> (w_result.packet_count == $past(w_result.packet_count) + 32'd1))
        else $error("packet count skipped");

    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && $past(w_fire) && $past(i_rst_n))
            |-> ((w_result.channels_seen & $past(w_result.channels_seen))
                 == $past(w_result.channels_seen)))
        else $error("channel presence lost");

endmodule
